/* rtl/core/fqmu_pkg.sv */
`default_nettype none

package fqmu_pkg;

    localparam int unsigned REQUESTERS_DEF     = 16;
    localparam int unsigned LOCKS_PER_HOME_DEF = 16;
    localparam int unsigned HOMES_DEF          = 4;

    localparam int unsigned MCNT_W    = 5;
    localparam logic [4:0]  MCNT_RST  = 5'd16;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_WAIT     = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/fair_queue_mutex_unit_core.sv */
`default_nettype none

// Hardware mutex unit with round-robin handoff. One request is taken per
// cycle (busy is always low). An accepted request is registered in the s1
// stage registers, then done, status and the notify outputs are registered
// from them. The receiver cannot stall, so results must be taken as they
// come. Each in-range request is a read-modify-write of one lock's waiting
// vector: the vector is read from the lock store at the accept edge,
// updated and written back on the next edge, with a bypass for
// back-to-back requests to the same lock. The lock store is cleared at reset
// through per-entry valid bits, so no clearing pass is needed. mutex_count
// may be written only while no request is in flight.
module fair_queue_mutex_unit_core #(
    parameter int unsigned REQUESTERS     = fqmu_pkg::REQUESTERS_DEF,
    parameter int unsigned LOCKS_PER_HOME = fqmu_pkg::LOCKS_PER_HOME_DEF,
    parameter int unsigned HOMES          = fqmu_pkg::HOMES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       action,
    input  wire logic [1:0] home_node,
    input  wire logic [3:0] lock_index,
    input  wire logic [3:0] requester,
    input  wire logic       cfg_wr_en,
    input  wire logic [4:0] cfg_wr_data,
    output logic            done,
    output logic [1:0]      status,
    output logic            notify_valid,
    output logic [3:0]      notify_requester
);

    localparam int unsigned DEPTH  = HOMES * LOCKS_PER_HOME;
    localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned REQ_W  = $clog2(REQUESTERS);
    localparam int unsigned SUM_W  = REQ_W + 1;

    typedef logic [REQUESTERS-1:0] vec_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [REQ_W-1:0]      req_t;

    logic [4:0]  mcnt_reg;
    vec_t        mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;

    logic        s1_valid_reg;
    logic        s1_ok_reg;
    logic        s1_action_reg;
    req_t        s1_req_reg;
    slot_t       s1_slot_reg;
    vec_t        rd_data_reg;
    logic        rd_vld_reg;
    logic        fwd_hit_reg;
    vec_t        fwd_data_reg;

    logic        accept;
    logic [31:0] lim;
    logic        ok_in;
    logic [31:0] slot_full;
    slot_t       slot_in;
    logic        hit;

    vec_t        cur;
    vec_t        mine;
    vec_t        v_next;
    logic [1:0]  status_next;
    logic        nvalid_next;
    logic [3:0]  nreq_next;
    logic [SUM_W-1:0]        shamt;
    logic [2*REQUESTERS-1:0] dbl;
    vec_t        rot;
    logic        found;
    req_t        pos;
    logic [SUM_W-1:0]        psum;
    logic [SUM_W-1:0]        pwrap;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        lim = (32'(mcnt_reg) > 32'(LOCKS_PER_HOME)) ? 32'(LOCKS_PER_HOME) : 32'(mcnt_reg);
        ok_in = (32'(lock_index) < lim) && (32'(home_node) < HOMES)
                && (32'(requester) < REQUESTERS);
        slot_full = 32'(home_node) * 32'(LOCKS_PER_HOME) + 32'(lock_index);
        slot_in   = slot_full[SLOT_W-1:0];
        hit = s1_valid_reg && s1_ok_reg && (s1_slot_reg == slot_in);
    end

    // update of the lock's waiting vector and round-robin handoff search
    always_comb
    begin
        cur  = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '0);
        mine = vec_t'(1) << s1_req_reg;
        shamt = SUM_W'(s1_req_reg) + SUM_W'(1);
        v_next = cur | mine;
        status_next = fqmu_pkg::ST_GRANTED;
        nvalid_next = 1'b0;
        nreq_next   = 4'd0;
        dbl   = '0;
        rot   = '0;
        found = 1'b0;
        pos   = '0;
        psum  = '0;
        pwrap = '0;
        if (!s1_ok_reg)
        begin
            v_next      = cur;
            status_next = fqmu_pkg::ST_RANGE;
        end
        else if (s1_action_reg == fqmu_pkg::ACT_ACQUIRE)
        begin
            v_next      = cur | mine;
            status_next = ((cur & ~mine) != '0) ? fqmu_pkg::ST_WAIT : fqmu_pkg::ST_GRANTED;
        end
        else
        begin
            v_next      = cur & ~mine;
            status_next = fqmu_pkg::ST_RELEASED;
            dbl = {v_next, v_next} >> shamt;
            rot = dbl[REQUESTERS-1:0];
            for (int i = REQUESTERS - 1; i >= 0; i--)
            begin
                if (rot[i])
                begin
                    found = 1'b1;
                    pos   = req_t'(i);
                end
            end
            psum  = shamt + SUM_W'(pos);
            pwrap = (32'(psum) >= REQUESTERS) ? psum - SUM_W'(REQUESTERS) : psum;
            nvalid_next = found;
            nreq_next   = found ? 4'(pwrap) : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg     <= fqmu_pkg::MCNT_RST;
            vld_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            done         <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mcnt_reg <= cfg_wr_data;
            end
            if (s1_valid_reg && s1_ok_reg)
            begin
                vld_reg[s1_slot_reg] <= 1'b1;
            end
            s1_valid_reg <= accept;
            fwd_hit_reg  <= accept && hit;
            done         <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_ok_reg)
        begin
            mem_reg[s1_slot_reg] <= v_next;
        end
        if (accept)
        begin
            rd_data_reg   <= mem_reg[slot_in];
            rd_vld_reg    <= vld_reg[slot_in];
            s1_ok_reg     <= ok_in;
            s1_action_reg <= action;
            s1_req_reg    <= req_t'(requester);
            s1_slot_reg   <= slot_in;
        end
        fwd_data_reg <= v_next;
        if (s1_valid_reg)
        begin
            status           <= status_next;
            notify_valid     <= nvalid_next;
            notify_requester <= nreq_next;
        end
    end

`ifndef ASSERT_OFF
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result missing two edges after transfer");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##2 !done)
        else $error("result without a transfer");

    a_notify_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        done && notify_valid |-> status == fqmu_pkg::ST_RELEASED)
        else $error("notify on a request other than release");

    a_notify_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && !notify_valid |-> notify_requester == 4'd0)
        else $error("notify requester set without notify");

    a_fwd_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ok_reg && accept && hit |=> fwd_hit_reg && s1_valid_reg)
        else $error("bypass missed for back-to-back request to one lock");
`endif

endmodule

`default_nettype wire
